[rtl/irrigation_sensor_valve_controller_defines.svh]
// Assertion macros shared by the irrigation sensor and valve controller RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef IRRIGATION_SENSOR_VALVE_CONTROLLER_DEFINES_SVH
`define IRRIGATION_SENSOR_VALVE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ISVC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ISVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/isvc_pkg.sv]
// Shared types and constants for the irrigation sensor and valve controller.
// No dependencies; every RTL module and interface imports this package.
package isvc_pkg;

    // Field widths fixed by the item format.
    localparam int ADC_BITS  = 10;
    localparam int CMD_W     = 3;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int DEPTH_W   = 4;
    localparam int LOG_W     = 8;
    localparam int PEAK_W    = 8;

    // Command codes carried by an input item.
    localparam logic [CMD_W-1:0] CMD_MOIST_SAMPLE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MOIST_END    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RAIN_SAMPLE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RAIN_END     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK         = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_DEPTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAIN_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAIN_PEAK_LIMIT = 3'd4;

    // Configuration reset values.
    localparam logic [DEPTH_W-1:0]  ROOT_DEPTH_RST = 4'd0;
    localparam logic [ADC_BITS-1:0] HIGH_LEVEL_RST = 10'd511;
    localparam logic [ADC_BITS-1:0] LOW_LEVEL_RST  = 10'd754;
    localparam logic [ADC_BITS-1:0] RAIN_LEVEL_RST = 10'd350;
    localparam logic [PEAK_W-1:0]   PEAK_LIMIT_RST = 8'd3;

    // Root depths from this value up use probe B; zero alternates.
    localparam logic [DEPTH_W-1:0] DEPTH_PROBE_B = 4'd4;
    localparam logic [PEAK_W-1:0]  PEAK_MAX      = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;        // execute the accepted item and load the result
        logic div_start;   // load the divider with the moisture sum
        logic div_step;    // one shift-subtract step of the divider
        logic div_finish;  // close the moisture window with the quotient
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;    // the offered item closes a non-empty moisture window
    } t_dp_status;

endpackage

[rtl/isvc_in_if.sv]
// Input item channel of the irrigation sensor and valve controller.
// Depends on isvc_pkg for field widths.
interface isvc_in_if;
    import isvc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ADC_BITS-1:0] adc_value;
    logic                manual_on;
    logic                manual_off;
    logic                battery_low;
    logic                schedule_active;

    modport source (
        output valid, cmd, adc_value, manual_on, manual_off, battery_low, schedule_active,
        input  ready
    );
    modport sink (
        input  valid, cmd, adc_value, manual_on, manual_off, battery_low, schedule_active,
        output ready
    );
endinterface

[rtl/isvc_out_if.sv]
// Result item channel of the irrigation sensor and valve controller.
// Depends on isvc_pkg for field widths.
interface isvc_out_if;
    import isvc_pkg::*;

    logic             valid;
    logic             ready;
    logic             valve_open;
    logic             charge_request;
    logic             probe_select;
    logic             log_valid;
    logic [LOG_W-1:0] log_byte;
    logic             is_raining;
    logic             is_high_moisture;
    logic             is_low_moisture;

    modport source (
        output valid, valve_open, charge_request, probe_select, log_valid, log_byte,
               is_raining, is_high_moisture, is_low_moisture,
        input  ready
    );
    modport sink (
        input  valid, valve_open, charge_request, probe_select, log_valid, log_byte,
               is_raining, is_high_moisture, is_low_moisture,
        output ready
    );
endinterface

[rtl/isvc_dp.sv]
// Datapath: configuration, sample accumulators, status flags, valve state,
// the shift-subtract divider for the moisture average and the result register.
// Depends on isvc_pkg.
module isvc_dp #(
    parameter int MAX_SAMPLES = 255
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [isvc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [isvc_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [isvc_pkg::CMD_W-1:0]    i_cmd,
    input  logic [isvc_pkg::ADC_BITS-1:0] i_adc_value,
    input  logic                          i_manual_on,
    input  logic                          i_manual_off,
    input  logic                          i_battery_low,
    input  logic                          i_schedule_active,
    input  isvc_pkg::t_dp_cmd             i_ctl,
    output isvc_pkg::t_dp_status          o_status,
    output logic                          o_valve_open,
    output logic                          o_charge_request,
    output logic                          o_probe_select,
    output logic                          o_log_valid,
    output logic [isvc_pkg::LOG_W-1:0]    o_log_byte,
    output logic                          o_is_raining,
    output logic                          o_is_high_moisture,
    output logic                          o_is_low_moisture
);
    import isvc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = ADC_BITS + CNT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    // Configuration registers.
    logic [DEPTH_W-1:0]  r_root_depth;
    logic [ADC_BITS-1:0] r_high_level, r_low_level, r_rain_level;
    logic [PEAK_W-1:0]   r_peak_limit;

    // Window accumulators, flags and valve.
    logic [CNT_W-1:0]  r_moist_count, n_moist_count;
    logic [SUM_W-1:0]  r_moist_sum, n_moist_sum;
    logic [CNT_W-1:0]  r_rain_count, n_rain_count;
    logic [PEAK_W-1:0] r_peak_count, n_peak_count;
    logic r_raining, n_raining, r_high, n_high, r_low, n_low, r_valve, n_valve;

    // Divider: remainder and the dividend that shifts into the quotient.
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [SUM_W-1:0] r_quo, n_quo;

    // Result register.
    logic             r_out_valve, n_out_valve, r_out_charge, n_out_charge;
    logic             r_out_probe, n_out_probe, r_out_lvalid, n_out_lvalid;
    logic [LOG_W-1:0] r_out_lbyte, n_out_lbyte;
    logic             r_out_raining, n_out_raining, r_out_high, n_out_high;
    logic             r_out_low, n_out_low;

    logic                w_probe;
    logic [CNT_W:0]      w_trial, w_diff;
    logic                w_ge;
    logic [ADC_BITS-1:0] w_avg;
    logic                w_moist_close;

    // Probe choice: zero depth alternates on count parity, shallow A, deep B.
    assign w_probe = (r_root_depth == '0) ? r_moist_count[0] :
                     (r_root_depth >= DEPTH_PROBE_B);

    // One restoring division step against the current sample count.
    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_moist_count};
    assign w_ge    = (w_trial >= {1'b0, r_moist_count});

    // The average of ADC readings always fits the ADC width; an empty window is zero.
    assign w_avg         = i_ctl.div_finish ? r_quo[ADC_BITS-1:0] : '0;
    assign w_moist_close = i_ctl.div_finish || (i_ctl.exec && (i_cmd == CMD_MOIST_END));

    assign o_status.need_div = (i_cmd == CMD_MOIST_END) && (r_moist_count != '0);

    // Next state of the block and of the result register.
    always_comb begin
        n_moist_count = r_moist_count;
        n_moist_sum   = r_moist_sum;
        n_rain_count  = r_rain_count;
        n_peak_count  = r_peak_count;
        n_raining     = r_raining;
        n_high        = r_high;
        n_low         = r_low;
        n_valve       = r_valve;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_out_valve   = r_out_valve;
        n_out_charge  = r_out_charge;
        n_out_probe   = r_out_probe;
        n_out_lvalid  = r_out_lvalid;
        n_out_lbyte   = r_out_lbyte;
        n_out_raining = r_out_raining;
        n_out_high    = r_out_high;
        n_out_low     = r_out_low;

        if (i_ctl.exec || i_ctl.div_finish) begin
            n_out_charge = 1'b0;
            n_out_probe  = 1'b0;
            n_out_lvalid = 1'b0;
            n_out_lbyte  = '0;
        end

        // Items executed directly, without the divider.
        if (i_ctl.exec) begin
            case (i_cmd)
                CMD_MOIST_SAMPLE: begin
                    n_out_probe = w_probe;
                    if (r_moist_count < CNT_MAX) begin
                        n_moist_count = r_moist_count + 1'b1;
                        n_moist_sum   = r_moist_sum + SUM_W'(i_adc_value);
                    end
                end
                CMD_RAIN_SAMPLE: begin
                    if (r_rain_count < CNT_MAX) begin
                        n_rain_count = r_rain_count + 1'b1;
                        if ((i_adc_value < r_rain_level) && (r_peak_count != PEAK_MAX)) begin
                            n_peak_count = r_peak_count + 1'b1;
                        end
                    end
                end
                CMD_RAIN_END: begin
                    n_out_lvalid = 1'b1;
                    n_out_lbyte  = r_peak_count;
                    n_raining    = (r_peak_count > r_peak_limit);
                    n_rain_count = '0;
                    n_peak_count = '0;
                end
                CMD_TICK: begin
                    if (!r_valve) begin
                        if (i_battery_low) begin
                            n_out_charge = 1'b1;
                        end else if (i_manual_on) begin
                            n_valve = 1'b1;
                        end else if (i_schedule_active && !i_manual_off && !r_raining
                                     && !r_high) begin
                            n_valve = 1'b1;
                        end else if (r_low && !i_manual_off && !r_raining) begin
                            n_valve = 1'b1;
                        end
                    end else if (!i_manual_on && (i_manual_off || r_raining || r_high
                                 || !i_schedule_active)) begin
                        n_valve = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        // Moisture window end: classify the average and clear the window.
        if (w_moist_close) begin
            n_out_lvalid  = 1'b1;
            n_out_lbyte   = w_avg[ADC_BITS-1:2];
            if (w_avg > r_high_level) begin
                n_high = 1'b1;
                n_low  = 1'b0;
            end else if (w_avg < r_low_level) begin
                n_high = 1'b0;
                n_low  = 1'b1;
            end else begin
                n_high = 1'b0;
                n_low  = 1'b0;
            end
            n_moist_count = '0;
            n_moist_sum   = '0;
        end

        // Divider load and steps.
        if (i_ctl.div_start) begin
            n_rem = '0;
            n_quo = r_moist_sum;
        end else if (i_ctl.div_step) begin
            n_rem = w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            n_quo = {r_quo[SUM_W-2:0], w_ge};
        end

        // The result reports the state after the item.
        if (i_ctl.exec || i_ctl.div_finish) begin
            n_out_valve   = n_valve;
            n_out_raining = n_raining;
            n_out_high    = n_high;
            n_out_low     = n_low;
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_depth  <= ROOT_DEPTH_RST;
            r_high_level  <= HIGH_LEVEL_RST;
            r_low_level   <= LOW_LEVEL_RST;
            r_rain_level  <= RAIN_LEVEL_RST;
            r_peak_limit  <= PEAK_LIMIT_RST;
            r_moist_count <= '0;
            r_moist_sum   <= '0;
            r_rain_count  <= '0;
            r_peak_count  <= '0;
            r_raining     <= 1'b0;
            r_high        <= 1'b0;
            r_low         <= 1'b0;
            r_valve       <= 1'b0;
        end else begin
            r_moist_count <= n_moist_count;
            r_moist_sum   <= n_moist_sum;
            r_rain_count  <= n_rain_count;
            r_peak_count  <= n_peak_count;
            r_raining     <= n_raining;
            r_high        <= n_high;
            r_low         <= n_low;
            r_valve       <= n_valve;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROOT_DEPTH:      r_root_depth <= i_cfg_wdata[DEPTH_W-1:0];
                    CFG_HIGH_LEVEL:      r_high_level <= i_cfg_wdata[ADC_BITS-1:0];
                    CFG_LOW_LEVEL:       r_low_level  <= i_cfg_wdata[ADC_BITS-1:0];
                    CFG_RAIN_LEVEL:      r_rain_level <= i_cfg_wdata[ADC_BITS-1:0];
                    CFG_RAIN_PEAK_LIMIT: r_peak_limit <= i_cfg_wdata[PEAK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Divider and result payload.
    always_ff @(posedge i_clk) begin
        r_rem         <= n_rem;
        r_quo         <= n_quo;
        r_out_valve   <= n_out_valve;
        r_out_charge  <= n_out_charge;
        r_out_probe   <= n_out_probe;
        r_out_lvalid  <= n_out_lvalid;
        r_out_lbyte   <= n_out_lbyte;
        r_out_raining <= n_out_raining;
        r_out_high    <= n_out_high;
        r_out_low     <= n_out_low;
    end

    assign o_valve_open       = r_out_valve;
    assign o_charge_request   = r_out_charge;
    assign o_probe_select     = r_out_probe;
    assign o_log_valid        = r_out_lvalid;
    assign o_log_byte         = r_out_lbyte;
    assign o_is_raining       = r_out_raining;
    assign o_is_high_moisture = r_out_high;
    assign o_is_low_moisture  = r_out_low;

endmodule

[rtl/isvc_ctrl.sv]
// Controller: item handshake, result valid and the divider sequencer.
// Depends on isvc_pkg and the assertion macros header.
`include "irrigation_sensor_valve_controller_defines.svh"

module isvc_ctrl #(
    parameter int DIV_STEPS = 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  isvc_pkg::t_dp_status i_status,
    output isvc_pkg::t_dp_cmd    o_cmd
);
    import isvc_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              w_slot_free, w_accept;

    // The result register is free when empty or being taken this cycle.
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Sequencer and commands to the datapath.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_status.need_div) begin
                        o_cmd.div_start = 1'b1;
                        n_step          = '0;
                        n_state         = ST_DIV;
                    end else begin
                        o_cmd.exec  = 1'b1;
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    o_cmd.div_finish = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // A divide item goes straight into the divider.
    `ISVC_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, o_cmd.div_start, r_state == ST_DIV, "divider did not start")
    // The divider runs exactly its step count before finishing.
    `ISVC_ASSERT_NEXT(a_div_last, i_clk, i_rst_n, (r_state == ST_DIV) && (r_step == STEP_LAST), r_state == ST_DONE, "divider step count wrong")
    // The result slot is already empty when a division completes.
    `ISVC_ASSERT_NOW(a_done_slot, i_clk, i_rst_n, r_state == ST_DONE, !r_out_valid, "result slot busy at divide end")
    // Every accepted item either produces a result or occupies the divider.
    `ISVC_ASSERT_NEXT(a_accept_path, i_clk, i_rst_n, w_accept, r_out_valid || (r_state == ST_DIV), "accepted item lost")

endmodule

[rtl/irrigation_sensor_valve_controller.sv]
// Irrigation sensor and valve controller. One item is in work at a time. Sample,
// rain window end, tick and unknown commands are executed on acceptance and
// their result is valid in the cycle after. A moisture window end with at least
// one sample is averaged by the one-bit-per-cycle shift-subtract divider, and
// the result is loaded once the result register is free. An empty moisture
// window ends without the divider, with an average of zero. The result
// register lets the next item be accepted in the cycle its predecessor's result
// is taken. Configuration writes are taken in any cycle and are registered before they act.
// Depends on isvc_pkg, isvc_in_if, isvc_out_if, isvc_ctrl and isvc_dp.
module irrigation_sensor_valve_controller #(
    parameter int MAX_SAMPLES = 255
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [isvc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [isvc_pkg::CFG_W-1:0]     i_cfg_wdata,
    isvc_in_if.sink                        i_in,
    isvc_out_if.source                     o_out
);
    import isvc_pkg::*;

    localparam int DIV_STEPS = ADC_BITS + $clog2(MAX_SAMPLES + 1);

    t_dp_cmd          w_cmd;
    t_dp_status       w_status;
    logic             w_in_ready, w_out_valid;
    logic             w_valve, w_charge, w_probe, w_lvalid;
    logic [LOG_W-1:0] w_lbyte;
    logic             w_raining, w_high, w_low;

    // Handshake and sequencing.
    isvc_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // State, arithmetic and result register.
    isvc_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_cmd              (i_in.cmd),
        .i_adc_value        (i_in.adc_value),
        .i_manual_on        (i_in.manual_on),
        .i_manual_off       (i_in.manual_off),
        .i_battery_low      (i_in.battery_low),
        .i_schedule_active  (i_in.schedule_active),
        .i_ctl              (w_cmd),
        .o_status           (w_status),
        .o_valve_open       (w_valve),
        .o_charge_request   (w_charge),
        .o_probe_select     (w_probe),
        .o_log_valid        (w_lvalid),
        .o_log_byte         (w_lbyte),
        .o_is_raining       (w_raining),
        .o_is_high_moisture (w_high),
        .o_is_low_moisture  (w_low)
    );

    // Channel connections.
    assign i_in.ready             = w_in_ready;
    assign o_out.valid            = w_out_valid;
    assign o_out.valve_open       = w_valve;
    assign o_out.charge_request   = w_charge;
    assign o_out.probe_select     = w_probe;
    assign o_out.log_valid        = w_lvalid;
    assign o_out.log_byte         = w_lbyte;
    assign o_out.is_raining       = w_raining;
    assign o_out.is_high_moisture = w_high;
    assign o_out.is_low_moisture  = w_low;

endmodule
